// ===== hw/rtl/lfid_pkg.sv =====
// ----------------------------------------------------------------------------
// lfid_pkg
// Shared types and constants of the lowest-free identifier allocator.
// ----------------------------------------------------------------------------
package lfid_pkg;

	localparam int ID_W         = 8;
	localparam int MAP_DEPTH    = 256;
	localparam int WORD_W       = 32;
	localparam int NUM_WORDS    = MAP_DEPTH / WORD_W;
	localparam int WADDR_W      = $clog2(NUM_WORDS);
	localparam int BIT_W        = $clog2(WORD_W);
	localparam int HW_W         = ID_W + 1;
	localparam int DEF_CAPACITY = 256;

	typedef enum logic [1:0] {
		CMD_RESERVE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_QUERY   = 2'd2,
		CMD_NOP     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_RANGE    = 2'd1,
		ST_RELEASED = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic               rd_en;
		logic [WADDR_W-1:0] rd_addr;
		logic               wr_en;
		logic [WADDR_W-1:0] wr_addr;
		logic [WORD_W-1:0]  wr_data;
	} map_req_t;

endpackage

// ===== hw/rtl/lfid_req_if.sv =====
// ----------------------------------------------------------------------------
// lfid_req_if
// Command channel: one word carries a command and an identifier.
// ----------------------------------------------------------------------------
interface lfid_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] id_in;

	modport source (output valid, output cmd, output id_in, input ready);
	modport sink (input valid, input cmd, input id_in, output ready);
endinterface

// ===== hw/rtl/lfid_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lfid_rsp_if
// Result channel: one word per command.
// ----------------------------------------------------------------------------
interface lfid_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] id_out;
	logic [1:0] status;
	logic       is_reserved;

	modport source (output valid, output id_out, output status, output is_reserved,
		input ready);
	modport sink (input valid, input id_out, input status, input is_reserved,
		output ready);
endinterface

// ===== hw/rtl/lfid_map_mem.sv =====
// ----------------------------------------------------------------------------
// lfid_map_mem
// Reservation bitmap: 32-bit words, one read and one write port, registered
// read data. Per-word valid bits make unwritten words read as zero.
// ----------------------------------------------------------------------------
module lfid_map_mem
	import lfid_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  map_req_t          req,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0]    mem [NUM_WORDS];
	logic [NUM_WORDS-1:0] wvalid_q;
	logic [WORD_W-1:0]    rword_s1;
	logic                 rok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wvalid_q <= '0;
			rok_s1   <= 1'b0;
		end else begin
			if (req.wr_en) begin
				wvalid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rok_s1 <= wvalid_q[req.rd_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rword_s1 <= mem[req.rd_addr];
		end
	end

	assign rdata = rok_s1 ? rword_s1 : '0;

`ifndef ASSERT_OFF
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd_en && req.wr_en))
		else $error("map read and write in the same cycle");
	a_wvalid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |=> wvalid_q[$past(req.wr_addr)])
		else $error("written word not marked valid");
	a_wvalid_grow: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(wvalid_q) >= $countones($past(wvalid_q)))
		else $error("word valid bit dropped");
`endif

endmodule

// ===== hw/rtl/lfid_ctrl.sv =====
// ----------------------------------------------------------------------------
// lfid_ctrl
// Command sequencer: scans the bitmap word by word for reserve, does a
// single read-modify-write for release and a single read for query, holds the high-water mark
// and the result register.
// ----------------------------------------------------------------------------
module lfid_ctrl
	import lfid_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic              clk,
	input  logic              arst_n,
	lfid_req_if.sink          req,
	lfid_rsp_if.source        rsp,
	output map_req_t          mem_req,
	input  logic [WORD_W-1:0] mem_rdata
);

	localparam int LIMIT = (CAPACITY < MAP_DEPTH) ? CAPACITY : MAP_DEPTH;
	localparam logic [HW_W-1:0] LIMIT_HW = HW_W'(LIMIT);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_CHK  = 4'b0100,
		S_PUSH = 4'b1000
	} state_t;

	state_t             state_q;
	logic [HW_W-1:0]    hw_q;
	logic [HW_W-1:0]    bound_q;
	logic [WADDR_W:0]   rd_w_q;
	logic [WADDR_W-1:0] rd_w_s1;
	logic               scan_vld_s1;
	cmd_t               cmd_q;
	logic [ID_W-1:0]    id_q;
	logic [ID_W-1:0]    res_id_q;
	status_t            res_st_q;
	logic               res_ans_q;
	logic               out_vld_q;
	logic [ID_W-1:0]    out_id_q;
	status_t            out_st_q;
	logic               out_ans_q;

	logic               accept;
	logic [HW_W-1:0]    base;
	logic               issue;
	logic [WORD_W-1:0]  free_mask;
	logic               hit;
	logic [BIT_W-1:0]   hit_pos;
	logic [ID_W-1:0]    hit_id;
	logic               scan_done;
	logic               scan_go;
	logic               id_ok;
	logic               id_bit;
	logic               push_fire;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign push_fire = (state_q == S_PUSH) && (!out_vld_q || rsp.ready);

	always_comb begin
		base = {rd_w_q, BIT_W'(0)};
		issue = base < bound_q;
		for (int j = 0; j < WORD_W; j++) begin
			free_mask[j] = !mem_rdata[j] && ({1'b0, rd_w_s1, BIT_W'(j)} < bound_q);
		end
		hit = |free_mask;
		hit_pos = '0;
		for (int j = WORD_W - 1; j >= 0; j--) begin
			if (free_mask[j]) begin
				hit_pos = BIT_W'(j);
			end
		end
		hit_id    = {rd_w_s1, hit_pos};
		scan_done = (state_q == S_SCAN) && scan_vld_s1 && (hit || !issue);
		scan_go   = (state_q == S_SCAN) && issue && !scan_done;
		id_ok     = {1'b0, id_q} < hw_q;
		id_bit    = mem_rdata[id_q[BIT_W-1:0]];

		mem_req = '0;
		if (scan_go) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = rd_w_q[WADDR_W-1:0];
		end else if (accept && (cmd_t'(req.cmd) == CMD_RELEASE
				|| cmd_t'(req.cmd) == CMD_QUERY)) begin
			mem_req.rd_en   = 1'b1;
			mem_req.rd_addr = req.id_in[ID_W-1:BIT_W];
		end
		if (scan_done && hit) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = rd_w_s1;
			mem_req.wr_data = mem_rdata | (WORD_W'(1) << hit_pos);
		end else if ((state_q == S_CHK) && (cmd_q == CMD_RELEASE) && id_ok && id_bit) begin
			mem_req.wr_en   = 1'b1;
			mem_req.wr_addr = id_q[ID_W-1:BIT_W];
			mem_req.wr_data = mem_rdata & ~(WORD_W'(1) << id_q[BIT_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			hw_q        <= '0;
			rd_w_q      <= '0;
			scan_vld_s1 <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_go;
			if (push_fire) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					rd_w_q <= '0;
					if (accept) begin
						case (cmd_t'(req.cmd))
							CMD_RESERVE: state_q <= S_SCAN;
							CMD_RELEASE: state_q <= S_CHK;
							CMD_QUERY:   state_q <= S_CHK;
							default:     state_q <= S_PUSH;
						endcase
					end
				end
				S_SCAN: begin
					if (scan_go) begin
						rd_w_q <= rd_w_q + (WADDR_W+1)'(1);
					end
					if (scan_done) begin
						if (hit && ({1'b0, hit_id} == hw_q)) begin
							hw_q <= hw_q + HW_W'(1);
						end
						state_q <= S_PUSH;
					end
				end
				S_CHK: state_q <= S_PUSH;
				S_PUSH: begin
					if (push_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd_t'(req.cmd);
			id_q      <= req.id_in;
			bound_q   <= (hw_q < LIMIT_HW) ? hw_q + HW_W'(1) : hw_q;
			res_id_q  <= req.id_in;
			res_st_q  <= ST_OK;
			res_ans_q <= 1'b0;
		end
		if (scan_go) begin
			rd_w_s1 <= rd_w_q[WADDR_W-1:0];
		end
		if (scan_done) begin
			res_id_q <= hit ? hit_id : '0;
			res_st_q <= hit ? ST_OK : ST_FULL;
		end
		if (state_q == S_CHK) begin
			if (cmd_q == CMD_RELEASE) begin
				res_st_q <= !id_ok ? ST_RANGE : (!id_bit ? ST_RELEASED : ST_OK);
			end else begin
				res_ans_q <= id_ok && id_bit;
			end
		end
		if (push_fire) begin
			out_id_q  <= res_id_q;
			out_st_q  <= res_st_q;
			out_ans_q <= res_ans_q;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.id_out      = out_id_q;
	assign rsp.status      = out_st_q;
	assign rsp.is_reserved = out_ans_q;

`ifndef ASSERT_OFF
	a_hw_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= LIMIT_HW)
		else $error("high-water mark above limit");
	a_hw_step: assert property (@(posedge clk) disable iff (!arst_n)
		(hw_q != $past(hw_q)) |-> (hw_q == $past(hw_q) + HW_W'(1)))
		else $error("high-water mark moved by more than one");
	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_req.wr_en |-> (state_q == S_SCAN || state_q == S_CHK))
		else $error("map write outside scan or check");
	a_hw_only_reserve: assert property (@(posedge clk) disable iff (!arst_n)
		(hw_q != $past(hw_q)) |-> ($past(state_q) == S_SCAN && $past(cmd_q) == CMD_RESERVE))
		else $error("high-water mark moved without a reserve");
`endif

endmodule

// ===== hw/rtl/lowest_free_id_allocator.sv =====
// ----------------------------------------------------------------------------
// lowest_free_id_allocator
// Hands out the lowest released identifier below the high-water mark, else
// the high-water value; releases and queries identifiers.
//
//   channel  modport  word
//   req      sink     cmd, id_in
//   rsp      source   id_out, status, is_reserved
//
// Reserve: scans w 32-bit bitmap words (1..8) in turn through the single map
// read port. Release: read-modify-write. Query: read. Unused: no map access.
// One command at a time; req is taken while the previous result waits on rsp.
// Reset: no clearing pass; unwritten map words read as zero.
// ----------------------------------------------------------------------------
module lowest_free_id_allocator
	import lfid_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input logic        clk,
	input logic        arst_n,
	lfid_req_if.sink   req,
	lfid_rsp_if.source rsp
);

	map_req_t          mem_req;
	logic [WORD_W-1:0] mem_rdata;

	lfid_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.mem_req  (mem_req),
		.mem_rdata(mem_rdata)
	);

	lfid_map_mem u_map (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

// ===== sim/lfid_grant_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfid_grant_checker
// Watches the command and result channels of the identifier allocator, keeps
// its own copy of the reserved marks and the high-water count, and compares
// every result word field by field against the predicted answer.
// ----------------------------------------------------------------------------
module lfid_grant_checker
	import lfid_pkg::*;
#(
	parameter int CAPACITY = DEF_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	lfid_req_if  req,
	lfid_rsp_if  rsp,
	output int   failures,
	output int   pending
);

	localparam int ISSUE_CAP = (CAPACITY < MAP_DEPTH) ? CAPACITY : MAP_DEPTH;

	typedef struct packed {
		cmd_t             op;
		logic [ID_W-1:0]  id;
		status_t          st;
		logic             rsv;
	} answer_t;

	bit      marked [MAP_DEPTH];
	int      issued;
	answer_t awaited_answers[$];

	function automatic answer_t allocate_step(cmd_t op, logic [ID_W-1:0] id);
		answer_t a;
		bit      found;
		a.op  = op;
		a.id  = id;
		a.st  = ST_OK;
		a.rsv = 1'b0;
		found = 1'b0;
		case (op)
			CMD_RESERVE: begin
				for (int i = 0; i < MAP_DEPTH; i++) begin
					if (!found && i < issued && !marked[i]) begin
						marked[i] = 1'b1;
						a.id      = i[ID_W-1:0];
						found     = 1'b1;
					end
				end
				if (!found) begin
					if (issued < ISSUE_CAP) begin
						marked[issued] = 1'b1;
						a.id           = issued[ID_W-1:0];
						issued++;
					end else begin
						a.id = '0;
						a.st = ST_FULL;
					end
				end
			end
			CMD_RELEASE: begin
				if (int'(id) >= issued)
					a.st = ST_RANGE;
				else if (!marked[id])
					a.st = ST_RELEASED;
				else
					marked[id] = 1'b0;
			end
			CMD_QUERY: begin
				a.rsv = (int'(id) < issued) && marked[id];
			end
			default: ;
		endcase
		return a;
	endfunction

	initial begin
		failures = 0;
		pending  = 0;
		issued   = 0;
		foreach (marked[i])
			marked[i] = 1'b0;
	end

	// result side first: a word returned at this edge belongs to an earlier command
	always @(posedge clk) begin
		answer_t want;
		if (arst_n) begin
			if (rsp.valid && rsp.ready) begin
				if (awaited_answers.size() == 0) begin
					if (failures < 10)
						$display("%0t: unexpected result id_out=%0d status=%0d is_reserved=%0b",
							$realtime, rsp.id_out, rsp.status, rsp.is_reserved);
					failures <= failures + 1;
				end else begin
					want = awaited_answers.pop_front();
					if (rsp.id_out !== want.id || rsp.status !== want.st
							|| rsp.is_reserved !== want.rsv) begin
						if (failures < 10)
							$display({"%0t: mismatch on %s: expected id_out=%0d status=%0d ",
								"is_reserved=%0b, got id_out=%0d status=%0d is_reserved=%0b"},
								$realtime, want.op.name(), want.id, want.st, want.rsv,
								rsp.id_out, rsp.status, rsp.is_reserved);
						failures <= failures + 1;
					end
				end
			end
			if (req.valid && req.ready)
				awaited_answers.push_back(allocate_step(cmd_t'(req.cmd), req.id_in));
			pending <= awaited_answers.size();
		end
	end

endmodule

// ===== sim/tb_lowest_free_id_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_free_id_allocator
// Drives directed and random reserve, release, query and unused commands
// into the allocator with random gaps on both channels, filling the map to
// capacity and churning it; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_lowest_free_id_allocator;
	import lfid_pkg::*;

	localparam int CAPACITY = DEF_CAPACITY;
	localparam int BLOCKS   = 14;
	localparam int PER_BLK  = 100;

	logic clk;
	logic arst_n;
	bit   calm;
	int   failures;
	int   pending;
	int   reserves_sent;

	lfid_req_if req ();
	lfid_rsp_if rsp ();

	lowest_free_id_allocator #(.CAPACITY(CAPACITY)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	lfid_grant_checker #(.CAPACITY(CAPACITY)) checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.failures (failures),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	task automatic send_cmd(cmd_t op, logic [7:0] id);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd   <= op;
		req.id_in <= id;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_id();
		int top;
		top = (reserves_sent > 255) ? 255 : reserves_sent;
		if ($urandom_range(0, 99) < 85)
			return 8'($urandom_range(0, top));
		return 8'($urandom_range(0, 255));
	endfunction

	// result side: random stalls, calm stretches keep ready high
	initial begin
		int gap;
		rsp.ready <= 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			gap = pick_gap();
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		int weights [BLOCKS] = '{75, 75, 75, 40, 60, 30, 85, 50, 20, 70, 45, 65, 35, 55};
		int r;
		cmd_t op;
		arst_n        <= 1'b0;
		req.valid     <= 1'b0;
		req.cmd       <= CMD_NOP;
		req.id_in     <= '0;
		calm          = 1'b0;
		reserves_sent = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// empty map: out of range at first, then three reserves, releases and re-releases
		send_cmd(CMD_QUERY, 8'd0);
		send_cmd(CMD_RELEASE, 8'd0);
		send_cmd(CMD_RELEASE, 8'd255);
		send_cmd(CMD_RESERVE, 8'hFF);
		send_cmd(CMD_RESERVE, 8'h00);
		send_cmd(CMD_RESERVE, 8'hAA);
		send_cmd(CMD_QUERY, 8'd1);
		send_cmd(CMD_QUERY, 8'd2);
		send_cmd(CMD_QUERY, 8'd255);
		send_cmd(CMD_RELEASE, 8'd3);
		send_cmd(CMD_RELEASE, 8'd1);
		send_cmd(CMD_RELEASE, 8'd1);
		send_cmd(CMD_QUERY, 8'd1);
		send_cmd(CMD_RELEASE, 8'd2);
		// hole refill, lowest first
		send_cmd(CMD_RESERVE, 8'h55);
		send_cmd(CMD_RESERVE, 8'h00);
		send_cmd(CMD_RESERVE, 8'hFF);
		send_cmd(CMD_NOP, 8'hA5);
		send_cmd(CMD_NOP, 8'h5A);
		send_cmd(CMD_QUERY, 8'd3);
		reserves_sent = 6;

		for (int b = 0; b < BLOCKS; b++) begin
			calm = (b % 4 == 3);
			if (b == 5)
				drain();
			for (int n = 0; n < PER_BLK; n++) begin
				r = $urandom_range(0, 99);
				if (r < weights[b]) begin
					op = CMD_RESERVE;
					reserves_sent++;
				end else begin
					r = $urandom_range(0, 99);
					op = (r < 55) ? CMD_RELEASE : (r < 94) ? CMD_QUERY : CMD_NOP;
				end
				send_cmd(op, (op == CMD_RESERVE) ? 8'($urandom_range(0, 255)) : pick_id());
			end
		end

		drain();
		repeat (30) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/lfid_pkg.sv
hw/rtl/lfid_req_if.sv
hw/rtl/lfid_rsp_if.sv
hw/rtl/lfid_map_mem.sv
hw/rtl/lfid_ctrl.sv
hw/rtl/lowest_free_id_allocator.sv
sim/lfid_grant_checker.sv
sim/tb_lowest_free_id_allocator.sv
